// File: hw/rtl/sacp_pkg.sv
// Package for the serial angle command to pulse block.
// Character codes, register indexes and the constant-divide parameters.
// No dependencies.
package sacp_pkg;

   localparam int MAX_DIGITS = 9;

   localparam int BYTE_WIDTH      = 8;
   localparam int TICKS_WIDTH     = 16;
   localparam int COUNT_WIDTH     = 4;
   localparam int CSR_INDEX_WIDTH = 4;

   localparam logic [BYTE_WIDTH-1:0] ANGLE_LIMIT = 8'd180;
   localparam logic [BYTE_WIDTH-1:0] CHAR_CR     = 8'd13;
   localparam logic [BYTE_WIDTH-1:0] CHAR_LF     = 8'd10;
   localparam logic [BYTE_WIDTH-1:0] CHAR_ZERO   = 8'd48;
   localparam logic [BYTE_WIDTH-1:0] CHAR_NINE   = 8'd57;

   localparam logic [TICKS_WIDTH-1:0] PULSE_MIN_RESET  = 16'd1000;
   localparam logic [TICKS_WIDTH-1:0] PULSE_SPAN_RESET = 16'd3999;

   // angle * span / 180 is done as ((angle * span) >> 2) / 45
   localparam int PROD_WIDTH   = BYTE_WIDTH + TICKS_WIDTH;  // 24
   localparam int QUART_WIDTH  = PROD_WIDTH - 2;            // 22
   localparam int RECIP_SHIFT  = 28;
   localparam int RECIP_WIDTH  = 23;
   localparam int DIV_SMALL    = 45;
   localparam logic [RECIP_WIDTH-1:0] RECIP_MULT = RECIP_WIDTH'((2 ** RECIP_SHIFT) / DIV_SMALL);
   localparam int RECIP_PROD_WIDTH = QUART_WIDTH + RECIP_WIDTH;  // 45

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_PULSE_MIN  = 4'd0,
      CSR_PULSE_SPAN = 4'd1
   } csr_index_type;

endpackage

// File: hw/rtl/serial_angle_command_to_pulse.sv
// Top level of the serial angle command to pulse block.
// Parses decimal angle lines and scales them to a pulse compare value.
// Depends on sacp_pkg.

// Every accepted byte yields one result item, echoing the byte; a CR or LF after at
// least one digit ends a command and reports success or out of range. The block
// takes one byte per cycle when the result side does not stall, and passes each
// result through the four-stage path: parse, the angle by span multiply, the
// reciprocal multiply that divides by 180, and the correction, offset add and
// saturation that update the held pulse.
// Register writes are taken on any cycle (csr_ready is always high).
module serial_angle_command_to_pulse
   import sacp_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [BYTE_WIDTH-1:0]      req_rx_byte,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [BYTE_WIDTH-1:0]      rsp_echo_byte,
   output logic                       rsp_command_done,
   output logic                       rsp_command_status,
   output logic [BYTE_WIDTH-1:0]      rsp_angle_value,
   output logic [TICKS_WIDTH-1:0]     rsp_pulse_ticks,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [TICKS_WIDTH-1:0]     csr_data
);

   // configuration
   logic [TICKS_WIDTH-1:0] pulse_min_ff, pulse_span_ff;

   // parser state
   logic [COUNT_WIDTH-1:0] digit_count_ff, digit_count_in;
   logic [BYTE_WIDTH-1:0]  acc_value_ff, acc_value_in;
   logic                   too_large_ff, too_large_in;
   logic [TICKS_WIDTH-1:0] held_pulse_ff, held_pulse_in;

   // parse results
   logic                   p_done, p_status;
   logic [BYTE_WIDTH-1:0]  p_angle;
   logic [10:0]            p_next;

   // stage A: parsed item
   logic                   a_valid_ff;
   logic [BYTE_WIDTH-1:0]  a_echo_ff, a_angle_ff;
   logic                   a_done_ff, a_status_ff;

   // stage B: angle * span
   logic                   b_valid_ff;
   logic [BYTE_WIDTH-1:0]  b_echo_ff, b_angle_ff;
   logic                   b_done_ff, b_status_ff;
   logic [PROD_WIDTH-1:0]  b_prod_ff;

   // stage C: approximate quotient
   logic                   c_valid_ff;
   logic [BYTE_WIDTH-1:0]  c_echo_ff, c_angle_ff;
   logic                   c_done_ff, c_status_ff;
   logic [QUART_WIDTH-1:0] c_quart_ff;
   logic [TICKS_WIDTH-1:0] c_quot_ff;
   logic [RECIP_PROD_WIDTH-1:0] recip_prod;

   // output stage
   logic                   out_valid_ff;
   logic [BYTE_WIDTH-1:0]  out_echo_ff, out_angle_ff;
   logic                   out_done_ff, out_status_ff;
   logic [TICKS_WIDTH-1:0] out_pulse_ff;

   logic [QUART_WIDTH-1:0] quot_times;
   logic [QUART_WIDTH-1:0] quot_rem;
   logic [TICKS_WIDTH:0]   quot_fixed;
   logic [TICKS_WIDTH:0]   pulse_sum;
   logic [TICKS_WIDTH-1:0] pulse_sat;

   logic ready_out, ready_c, ready_b, ready_a, accept;

   assign ready_out = !out_valid_ff || !rsp_stall;
   assign ready_c   = !c_valid_ff || ready_out;
   assign ready_b   = !b_valid_ff || ready_c;
   assign ready_a   = !a_valid_ff || ready_b;
   assign req_stall = !ready_a;
   assign accept    = req_valid && ready_a;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pulse_min_ff  <= PULSE_MIN_RESET;
         pulse_span_ff <= PULSE_SPAN_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_PULSE_MIN:  pulse_min_ff  <= csr_data;
            CSR_PULSE_SPAN: pulse_span_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // character parser
   always_comb begin
      digit_count_in = digit_count_ff;
      acc_value_in   = acc_value_ff;
      too_large_in   = too_large_ff;
      p_done         = 1'b0;
      p_status       = 1'b0;
      p_angle        = '0;
      p_next         = 11'(acc_value_ff) * 11'd10 + 11'(req_rx_byte[3:0]);
      if (req_rx_byte inside {CHAR_CR, CHAR_LF}) begin
         if (digit_count_ff != '0) begin
            p_done = 1'b1;
            if (too_large_ff || acc_value_ff > ANGLE_LIMIT) begin
               p_status = 1'b1;
            end else begin
               p_angle = acc_value_ff;
            end
            digit_count_in = '0;
            acc_value_in   = '0;
            too_large_in   = 1'b0;
         end
      end else if (req_rx_byte inside {[CHAR_ZERO:CHAR_NINE]} &&
                   digit_count_ff < COUNT_WIDTH'(MAX_DIGITS)) begin
         digit_count_in = digit_count_ff + 1'b1;
         if (!too_large_ff) begin
            if (p_next > 11'(ANGLE_LIMIT)) begin
               too_large_in = 1'b1;
               acc_value_in = '0;
            end else begin
               acc_value_in = p_next[BYTE_WIDTH-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         digit_count_ff <= '0;
         acc_value_ff   <= '0;
         too_large_ff   <= 1'b0;
      end else if (accept) begin
         digit_count_ff <= digit_count_in;
         acc_value_ff   <= acc_value_in;
         too_large_ff   <= too_large_in;
      end
   end

   // stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (ready_a)   a_valid_ff   <= accept;
         if (ready_b)   b_valid_ff   <= a_valid_ff;
         if (ready_c)   c_valid_ff   <= b_valid_ff;
         if (ready_out) out_valid_ff <= c_valid_ff;
      end
   end

   // stage payloads
   always_ff @(posedge clock) begin
      if (accept) begin
         a_echo_ff   <= req_rx_byte;
         a_angle_ff  <= p_angle;
         a_done_ff   <= p_done;
         a_status_ff <= p_status;
      end
      if (ready_b && a_valid_ff) begin
         b_echo_ff   <= a_echo_ff;
         b_angle_ff  <= a_angle_ff;
         b_done_ff   <= a_done_ff;
         b_status_ff <= a_status_ff;
         b_prod_ff   <= PROD_WIDTH'(a_angle_ff) * PROD_WIDTH'(pulse_span_ff);
      end
      if (ready_c && b_valid_ff) begin
         c_echo_ff   <= b_echo_ff;
         c_angle_ff  <= b_angle_ff;
         c_done_ff   <= b_done_ff;
         c_status_ff <= b_status_ff;
         c_quart_ff  <= b_prod_ff[PROD_WIDTH-1:2];
         c_quot_ff   <= recip_prod[RECIP_SHIFT+TICKS_WIDTH-1:RECIP_SHIFT];
      end
   end

   // the reciprocal undershoots by at most one
   assign recip_prod = RECIP_PROD_WIDTH'(b_prod_ff[PROD_WIDTH-1:2]) *
                       RECIP_PROD_WIDTH'(RECIP_MULT);

   always_comb begin
      quot_times = QUART_WIDTH'(c_quot_ff) * QUART_WIDTH'(DIV_SMALL);
      quot_rem   = c_quart_ff - quot_times;
      quot_fixed = (TICKS_WIDTH+1)'(c_quot_ff) +
                   (TICKS_WIDTH+1)'(quot_rem >= QUART_WIDTH'(DIV_SMALL));
      pulse_sum  = (TICKS_WIDTH+1)'(pulse_min_ff) + quot_fixed;
      pulse_sat  = pulse_sum[TICKS_WIDTH] ? '1 : pulse_sum[TICKS_WIDTH-1:0];
      held_pulse_in = (c_done_ff && !c_status_ff) ? pulse_sat : held_pulse_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_pulse_ff <= PULSE_MIN_RESET;
      end else if (ready_out && c_valid_ff) begin
         held_pulse_ff <= held_pulse_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ready_out && c_valid_ff) begin
         out_echo_ff   <= c_echo_ff;
         out_angle_ff  <= c_angle_ff;
         out_done_ff   <= c_done_ff;
         out_status_ff <= c_status_ff;
         out_pulse_ff  <= held_pulse_in;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_echo_byte      = out_echo_ff;
   assign rsp_command_done   = out_done_ff;
   assign rsp_command_status = out_status_ff;
   assign rsp_angle_value    = out_angle_ff;
   assign rsp_pulse_ticks    = out_pulse_ff;

   // out of range results carry no angle and always end a command
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_command_status |-> rsp_command_done && rsp_angle_value == '0)
      else $error("status set without a finished command or with an angle");

   // the held pulse moves only with a successful command entering the output stage
   assert property (@(posedge clock) disable iff (reset)
      !$stable(held_pulse_ff) |-> rsp_valid && rsp_command_done && !rsp_command_status
                                  && rsp_pulse_ticks == held_pulse_ff)
      else $error("held pulse changed without a successful command");

   assert property (@(posedge clock) disable iff (reset)
      digit_count_ff <= COUNT_WIDTH'(MAX_DIGITS))
      else $error("digit count beyond limit");

   // input stalls only when the front stage is occupied and cannot move
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> a_valid_ff && b_valid_ff && c_valid_ff && out_valid_ff)
      else $error("input stalled with room in the pipeline");

endmodule
